// File: rtl/dtmf_pkg.sv
// dtmf_pkg: operation codes, widths and tone tables for the dtmf tone generator
// no dependencies; imported by dtmf_tone_generator_top
`timescale 1ns / 1ps
`default_nettype none

package dtmf_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CoefWidth   = 9;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned ToneWidth   = 3;
  localparam int unsigned CoefShift   = 8;
  localparam int unsigned ProdWidth   = CoefWidth + 1 + SampleWidth;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef logic [ToneWidth-1:0]          tone_idx_t;
  typedef logic [CoefWidth-1:0]          coef_t;
  typedef logic signed [SampleWidth-1:0] smp_t;

  // resonator coefficient per tone: 697, 770, 852, 941, 1209, 1336, 1477, 1633 Hz
  function automatic coef_t tone_coef(input tone_idx_t idx);
    coef_t c;
    case (idx)
      3'd0:    c = 9'd437;
      3'd1:    c = 9'd421;
      3'd2:    c = 9'd402;
      3'd3:    c = 9'd378;
      3'd4:    c = 9'd298;
      3'd5:    c = 9'd255;
      3'd6:    c = 9'd204;
      3'd7:    c = 9'd146;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // starting amplitude per tone
  function automatic smp_t tone_amp(input tone_idx_t idx);
    smp_t a;
    case (idx)
      3'd0:    a = -16'sd12073;
      3'd1:    a = -16'sd13189;
      3'd2:    a = -16'sd14389;
      3'd3:    a = -16'sd15625;
      3'd4:    a = -16'sd18863;
      3'd5:    a = -16'sd20113;
      3'd6:    a = -16'sd21268;
      3'd7:    a = -16'sd22240;
      default: a = '0;
    endcase
    return a;
  endfunction

  // row tone of each key code
  function automatic tone_idx_t digit_low(input logic [DigitWidth-1:0] d);
    tone_idx_t t;
    case (d)
      4'd0:                       t = 3'd3;
      4'd1, 4'd2, 4'd3, 4'd10:    t = 3'd0;
      4'd4, 4'd5, 4'd6, 4'd11:    t = 3'd1;
      4'd7, 4'd8, 4'd9, 4'd12:    t = 3'd2;
      4'd13, 4'd14, 4'd15:        t = 3'd3;
      default:                    t = 3'd0;
    endcase
    return t;
  endfunction

  // column tone of each key code
  function automatic tone_idx_t digit_high(input logic [DigitWidth-1:0] d);
    tone_idx_t t;
    case (d)
      4'd1, 4'd4, 4'd7, 4'd14:    t = 3'd4;
      4'd0, 4'd2, 4'd5, 4'd8:     t = 3'd5;
      4'd3, 4'd6, 4'd9, 4'd15:    t = 3'd6;
      4'd10, 4'd11, 4'd12, 4'd13: t = 3'd7;
      default:                    t = 3'd4;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dtmf_tone_generator_top.sv
// dtmf tone generator: two recursive sine resonators summed into one pcm stream
// depends on dtmf_pkg (operation codes, tone tables)
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel (in_valid / in_ready): each item carries operation and digit.
//   a load item (operation = load) selects the key; its row and column tones
//   set the coefficients, clear the first history and preset the second one
//   to the tone amplitude. a load produces no output item.
//   a tick item (operation = tick) steps both resonators once and yields one
//   signed 16-bit sample, the floor average of the two resonator outputs.
//   output channel (out_valid / out_ready): one sample item per tick.
// timing
//   a tick's sample appears in the output register in the cycle after acceptance.
//   one item is accepted every cycle as long as the output register is empty
//   or being drained in the same cycle; the rate is set by the single
//   multiply-subtract step per resonator between the history registers.
// reset and stall
//   rst (synchronous) clears coefficients and histories, so ticks before the
//   first load give zero samples, and empties the output register.
//   while out_ready is low with a sample held, in_ready drops and the held
//   sample stays unchanged.
module dtmf_tone_generator_top
  import dtmf_pkg::*;
(
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          in_valid,
  output logic                                in_ready,
  input  wire  logic                          operation,
  input  wire  logic [DigitWidth-1:0]         digit,
  output logic                                out_valid,
  input  wire  logic                          out_ready,
  output logic signed [SampleWidth-1:0]       sample
);

  // resonator state
  coef_t low_coef;
  coef_t high_coef;
  smp_t  low_prev;
  smp_t  low_prev2;
  smp_t  high_prev;
  smp_t  high_prev2;

  logic  accept;
  logic  is_tick;

  tone_idx_t low_idx;
  tone_idx_t high_idx;

  logic signed [ProdWidth-1:0] low_prod;
  logic signed [ProdWidth-1:0] high_prod;
  smp_t                        low_y;
  smp_t                        high_y;
  logic signed [SampleWidth:0] sum;

  // output register accepts a new sample when empty or draining
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_tick  = (operation == OP_TICK);

  assign low_idx  = digit_low(digit);
  assign high_idx = digit_high(digit);

  // y = floor(coef * prev / 256) - prev2, wrapped to 16 bits
  assign low_prod  = $signed({1'b0, low_coef}) * low_prev;
  assign high_prod = $signed({1'b0, high_coef}) * high_prev;
  assign low_y     = SampleWidth'(low_prod[CoefShift +: SampleWidth] - low_prev2);
  assign high_y    = SampleWidth'(high_prod[CoefShift +: SampleWidth] - high_prev2);

  // floor halving of the sum always fits the sample width
  assign sum = {low_y[SampleWidth-1], low_y} + {high_y[SampleWidth-1], high_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      low_coef   <= '0;
      high_coef  <= '0;
      low_prev   <= '0;
      low_prev2  <= '0;
      high_prev  <= '0;
      high_prev2 <= '0;
    end else if (accept) begin
      if (is_tick) begin
        low_prev2  <= low_prev;
        low_prev   <= low_y;
        high_prev2 <= high_prev;
        high_prev  <= high_y;
      end else begin
        // new key: preset each resonator with its own amplitude
        low_coef   <= tone_coef(low_idx);
        high_coef  <= tone_coef(high_idx);
        low_prev   <= '0;
        low_prev2  <= tone_amp(low_idx);
        high_prev  <= '0;
        high_prev2 <= tone_amp(high_idx);
      end
    end
  end

  // output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && is_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && is_tick) begin
      sample <= sum[SampleWidth:1];
    end
  end

endmodule

`default_nettype wire
